// ===== hdl/dense_graph_shortest_path_eccentricity_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property shorthands for the shortest-path eccentricity checkers.
// ----------------------------------------------------------------------------
`ifndef DENSE_GRAPH_SHORTEST_PATH_ECCENTRICITY_MACROS_SVH
`define DENSE_GRAPH_SHORTEST_PATH_ECCENTRICITY_MACROS_SVH

// same-cycle implication
`define DGSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DGSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/dgse_pkg.sv =====
// ----------------------------------------------------------------------------
// dgse_pkg
// Shared types and constants of the shortest-path eccentricity block.
// ----------------------------------------------------------------------------
package dgse_pkg;

   localparam int NODE_PORT_W   = 7;
   localparam int WEIGHT_PORT_W = 16;
   localparam int CFG_W         = 8;
   localparam int RESULT_W      = 23;

   localparam logic [RESULT_W-1:0] OUT_MAX = 23'd8388607;

   typedef enum logic [0:0] {
      ALU_SELECT = 1'b0,
      ALU_RELAX  = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic less;
      logic a_zero;
      logic b_zero;
      logic c_zero;
   } alu_flags_type;

endpackage

// ===== hdl/dgse_ram.sv =====
// ----------------------------------------------------------------------------
// dgse_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dgse_ram #(
   parameter int ADDR_W = 7,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/dgse_alu.sv =====
// ----------------------------------------------------------------------------
// dgse_alu
// Shared adder and comparator: the comparator serves both the select and relax scans, the adder only the relax scan.
// ----------------------------------------------------------------------------
module dgse_alu
   import dgse_pkg::*;
#(
   parameter int DIST_W = 23
) (
   input  alu_op_type        op,
   input  logic [DIST_W-1:0] opa,
   input  logic [DIST_W-1:0] opb,
   input  logic [DIST_W-1:0] opc,
   output logic [DIST_W-1:0] sum,
   output alu_flags_type     flags
);

   logic [DIST_W-1:0] cmp_lhs;
   logic [DIST_W-1:0] cmp_rhs;

   assign sum = opa + opb;

   always_comb begin
      case (op)
         ALU_RELAX: begin
            cmp_lhs = sum;
            cmp_rhs = opc;
         end
         ALU_SELECT: begin
            cmp_lhs = opa;
            cmp_rhs = opb;
         end
         default: begin
            cmp_lhs = opa;
            cmp_rhs = opb;
         end
      endcase
   end

   always_comb begin
      flags.less   = cmp_lhs < cmp_rhs;
      flags.a_zero = (opa == '0);
      flags.b_zero = (opb == '0);
      flags.c_zero = (opc == '0);
   end

endmodule

// ===== hdl/dense_graph_shortest_path_eccentricity.sv =====
// Throughput: one edge per cycle while loading; none taken during a run or
//   while a finished result waits; each scan reads the node table once per node.
// Reset (synchronous, high): loading phase, node count 1, no result pending;
//   the weight RAM is not cleared.
// ----------------------------------------------------------------------------
// dense_graph_shortest_path_eccentricity
// Dense-matrix Dijkstra from node 0; reports the largest finite distance.
// ----------------------------------------------------------------------------
module dense_graph_shortest_path_eccentricity
   import dgse_pkg::*;
#(
   parameter int MAX_NODES   = 128,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [NODE_PORT_W-1:0]   req_row_node,
   input  logic [NODE_PORT_W-1:0]   req_column_node,
   input  logic [WEIGHT_PORT_W-1:0] req_edge_weight,
   input  logic                     req_no_link,
   input  logic                     req_last_edge,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [RESULT_W-1:0]      rsp_max_distance,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CFG_W-1:0]         csr_node_count
);

   localparam int NODE_W  = $clog2(MAX_NODES);
   localparam int DIST_W  = WEIGHT_BITS + NODE_W;
   localparam int CNT_A   = $clog2(MAX_NODES + 1);
   localparam int CNT_W   = (CNT_A > CFG_W) ? CNT_A : CFG_W;
   localparam int WADDR_W = 2 * NODE_W;
   localparam int XW      = (DIST_W > RESULT_W) ? DIST_W : RESULT_W;

   typedef enum logic [4:0] {
      S_LOAD  = 5'b00001,
      S_INIT  = 5'b00010,
      S_SEL   = 5'b00100,
      S_RELAX = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [CFG_W-1:0]     node_count_ff, node_count_in;
   logic [NODE_W-1:0]    nlast_ff, nlast_in;
   logic [NODE_W-1:0]    ix_ff, ix_in;
   logic                 iss_ff, iss_in;
   logic                 pv_ff, pv_in;
   logic [NODE_W-1:0]    pidx_ff, pidx_in;
   logic                 found_ff, found_in;
   logic [DIST_W-1:0]    best_ff, best_in;
   logic [NODE_W-1:0]    sel_ff, sel_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RESULT_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                 req_take;
   logic                 in_range;
   logic [NODE_W-1:0]    row_idx, col_idx, hi_idx, lo_idx;
   logic [CNT_W-1:0]     n_req, n_eff;
   logic                 scan_end, rsp_load;

   logic                 wm_we;
   logic [WADDR_W-1:0]   wm_waddr, wm_raddr;
   logic [WEIGHT_BITS-1:0] wm_wdata, wm_rdata;
   logic [NODE_W-1:0]    rl_hi, rl_lo;

   logic                 nt_we;
   logic [DIST_W:0]      nt_wdata, nt_rdata;
   logic                 nt_vis;
   logic [DIST_W-1:0]    nt_dist, w_ext;

   alu_op_type           alu_op;
   logic [DIST_W-1:0]    alu_a, alu_b, alu_sum;
   alu_flags_type        alu_flags;
   logic [XW-1:0]        best_wide;

   // ---------------- input side and weight store ----------------
   assign req_stall = (state_ff != S_LOAD);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_range = (32'(req_row_node) < MAX_NODES) && (32'(req_column_node) < MAX_NODES);
   assign row_idx  = NODE_W'(req_row_node);
   assign col_idx  = NODE_W'(req_column_node);
   // one copy per pair, keyed by (larger, smaller) endpoint
   assign hi_idx   = (row_idx > col_idx) ? row_idx : col_idx;
   assign lo_idx   = (row_idx > col_idx) ? col_idx : row_idx;

   assign wm_we    = req_take && in_range;
   assign wm_waddr = {hi_idx, lo_idx};
   assign wm_wdata = req_no_link ? '0 : WEIGHT_BITS'(req_edge_weight);

   assign rl_hi    = (sel_ff > ix_ff) ? sel_ff : ix_ff;
   assign rl_lo    = (sel_ff > ix_ff) ? ix_ff : sel_ff;
   assign wm_raddr = (state_ff == S_INIT) ? {ix_ff, NODE_W'(0)} : {rl_hi, rl_lo};

   dgse_ram #(
      .ADDR_W (WADDR_W),
      .DATA_W (WEIGHT_BITS)
   ) u_wmem (
      .clock   (clock),
      .wr_en   (wm_we),
      .wr_addr (wm_waddr),
      .wr_data (wm_wdata),
      .rd_addr (wm_raddr),
      .rd_data (wm_rdata)
   );

   // ---------------- node table: {visited, distance} ----------------
   assign nt_vis  = nt_rdata[DIST_W];
   assign nt_dist = nt_rdata[DIST_W-1:0];
   assign w_ext   = DIST_W'(wm_rdata);

   dgse_ram #(
      .ADDR_W (NODE_W),
      .DATA_W (DIST_W + 1)
   ) u_ntab (
      .clock   (clock),
      .wr_en   (nt_we),
      .wr_addr (pidx_ff),
      .wr_data (nt_wdata),
      .rd_addr (ix_ff),
      .rd_data (nt_rdata)
   );

   // ---------------- shared arithmetic ----------------
   assign alu_op = (state_ff == S_RELAX) ? ALU_RELAX : ALU_SELECT;
   assign alu_a  = (state_ff == S_RELAX) ? best_ff : nt_dist;
   assign alu_b  = (state_ff == S_RELAX) ? w_ext : best_ff;

   dgse_alu #(
      .DIST_W (DIST_W)
   ) u_alu (
      .op    (alu_op),
      .opa   (alu_a),
      .opb   (alu_b),
      .opc   (nt_dist),
      .sum   (alu_sum),
      .flags (alu_flags)
   );

   // ---------------- sequencer ----------------
   assign n_req     = CNT_W'(node_count_ff);
   assign n_eff     = (n_req > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : n_req;
   assign scan_end  = !iss_ff && !pv_ff;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign best_wide = XW'(best_ff);

   always_comb begin
      state_in      = state_ff;
      node_count_in = node_count_ff;
      nlast_in      = nlast_ff;
      ix_in         = ix_ff;
      iss_in        = iss_ff;
      pv_in         = iss_ff;
      pidx_in       = ix_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      sel_in        = sel_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      nt_we         = 1'b0;
      nt_wdata      = {1'b0, w_ext};

      if (csr_valid && csr_ready) begin
         node_count_in = csr_node_count;
      end

      if (iss_ff) begin
         ix_in = ix_ff + NODE_W'(1);
         if (ix_ff == nlast_ff) begin
            iss_in = 1'b0;
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_LOAD: begin
            if (req_take && req_last_edge) begin
               best_in  = '0;
               nlast_in = NODE_W'(n_eff - CNT_W'(1));
               ix_in    = NODE_W'(1);
               if (n_eff <= CNT_W'(1)) begin
                  state_in = S_DONE;
               end else begin
                  iss_in   = 1'b1;
                  state_in = S_INIT;
               end
            end
         end
         S_INIT: begin
            // distance seeded with the direct link to node 0
            if (pv_ff) begin
               nt_we    = 1'b1;
               nt_wdata = {1'b0, w_ext};
            end
            if (scan_end) begin
               ix_in    = NODE_W'(1);
               iss_in   = 1'b1;
               found_in = 1'b0;
               state_in = S_SEL;
            end
         end
         S_SEL: begin
            if (pv_ff && !nt_vis && !alu_flags.a_zero && (!found_ff || alu_flags.less)) begin
               found_in = 1'b1;
               best_in  = nt_dist;
               sel_in   = pidx_ff;
            end
            if (scan_end) begin
               // if nothing is left to pick, best still holds the last (largest) pick
               if (found_ff) begin
                  ix_in    = NODE_W'(1);
                  iss_in   = 1'b1;
                  state_in = S_RELAX;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_RELAX: begin
            if (pv_ff) begin
               if (pidx_ff == sel_ff) begin
                  nt_we    = 1'b1;
                  nt_wdata = {1'b1, nt_dist};
               end else if (!nt_vis && !alu_flags.b_zero &&
                            (alu_flags.c_zero || alu_flags.less)) begin
                  nt_we    = 1'b1;
                  nt_wdata = {1'b0, alu_sum};
               end
            end
            if (scan_end) begin
               ix_in    = NODE_W'(1);
               iss_in   = 1'b1;
               found_in = 1'b0;
               state_in = S_SEL;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (best_wide > XW'(OUT_MAX)) ? OUT_MAX
                                                         : best_wide[RESULT_W-1:0];
               state_in     = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
            iss_in   = 1'b0;
            pv_in    = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         node_count_ff <= CFG_W'(1);
         iss_ff        <= 1'b0;
         pv_ff         <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         iss_ff        <= iss_in;
         pv_ff         <= pv_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nlast_ff    <= nlast_in;
      ix_ff       <= ix_in;
      pidx_ff     <= pidx_in;
      best_ff     <= best_in;
      sel_ff      <= sel_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_max_distance = rsp_data_ff;

endmodule

// ===== hdl/dgse_checker.sv =====
// ----------------------------------------------------------------------------
// dgse_checker
// Port-level checks of the shortest-path eccentricity block, bound to the top.
// ----------------------------------------------------------------------------
`include "dense_graph_shortest_path_eccentricity_macros.svh"

module dgse_checker
   import dgse_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                req_last_edge,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [RESULT_W-1:0] rsp_max_distance
);

   // an ordinary edge never stops the loading phase
   `DGSE_ASSERT_NEXT(a_edge_keeps_ready, clock, reset, req_valid && !req_stall && !req_last_edge, !req_stall, "edge transfer stalled the input")

   // a last edge always ends the loading phase
   `DGSE_ASSERT_NEXT(a_last_starts_run, clock, reset, req_valid && !req_stall && req_last_edge, req_stall, "last edge did not start a run")

   // a result only appears at the end of a run
   `DGSE_ASSERT_NOW(a_rsp_after_run, clock, reset, $rose(rsp_valid), $past(req_stall), "result without a run")

   `DGSE_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")

   `DGSE_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_max_distance), "result changed while stalled")

endmodule

bind dense_graph_shortest_path_eccentricity dgse_checker u_dgse_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_last_edge    (req_last_edge),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_max_distance (rsp_max_distance)
);
